// ===== design/mctt_pkg.sv =====
// Shared constants, codes and types for the multi-channel tick timer.
`default_nettype none

package mctt_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int SLOT_LIMIT = 16;
    localparam int SLOT_COUNT = (NUM_TIMERS < SLOT_LIMIT) ? NUM_TIMERS : SLOT_LIMIT;
    localparam int SLOT_W     = 4;
    localparam int COUNT_W    = 31;
    localparam int TICK_W     = 16;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_CREATE  = 2'd1,
        CMD_RESET   = 2'd2,
        CMD_DESTROY = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_CREATED = 2'd0,
        KIND_FAILED  = 2'd1,
        KIND_EXPIRED = 2'd2,
        KIND_DONE    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FAIL,
        ST_DONE
    } t_state;

    // token walking down the chain of cells
    typedef struct packed {
        logic valid;
        logic claimed;
    } t_tok;

    // command item held for the whole walk, seen by every cell
    typedef struct packed {
        t_cmd                cmd;
        logic [SLOT_W-1:0]   slot;
        logic [COUNT_W-1:0]  init;
        logic [COUNT_W-1:0]  ival;
        logic [TICK_W-1:0]   ticks;
    } t_job;

endpackage

`default_nettype wire

// ===== design/mctt_cell.sv =====
// One timer cell: use bit, count and reload interval, worked on as the token passes.
`default_nettype none

module mctt_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  logic [mctt_pkg::SLOT_W-1:0] i_index,
    input  mctt_pkg::t_job              i_job,
    input  mctt_pkg::t_tok              i_tok,
    output mctt_pkg::t_tok              o_tok,
    output logic                        o_fire
);
    import mctt_pkg::*;

    t_tok               r_tok;
    logic               r_used;
    logic               n_used;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic [COUNT_W-1:0] r_ival;
    logic [COUNT_W-1:0] n_ival;
    logic [COUNT_W-1:0] ticks_ext;
    logic               hit;

    assign ticks_ext = COUNT_W'(i_job.ticks);
    assign hit       = (i_job.slot == i_index);

    always_comb begin
        n_used  = r_used;
        n_count = r_count;
        n_ival  = r_ival;
        o_tok   = r_tok;
        o_fire  = 1'b0;
        if (r_tok.valid) begin
            case (i_job.cmd)
                CMD_TICK: begin
                    if (r_used && (r_count != '0)) begin
                        if (r_count > ticks_ext) begin
                            n_count = r_count - ticks_ext;
                        end else begin
                            o_fire  = 1'b1;
                            n_count = r_ival;
                        end
                    end
                end
                CMD_CREATE: begin
                    // first free cell on the walk takes it
                    if (!r_tok.claimed && !r_used) begin
                        n_used        = 1'b1;
                        n_count       = i_job.init;
                        n_ival        = i_job.ival;
                        o_fire        = 1'b1;
                        o_tok.claimed = 1'b1;
                    end
                end
                CMD_RESET: begin
                    if (hit && r_used) begin
                        n_count = i_job.init;
                        n_ival  = i_job.ival;
                    end
                end
                CMD_DESTROY: begin
                    if (hit && r_used) begin
                        n_used  = 1'b0;
                        n_count = '0;
                        n_ival  = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok  <= '0;
            r_used <= 1'b0;
        end else if (i_adv) begin
            r_tok  <= i_tok;
            r_used <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_count <= n_count;
            r_ival  <= n_ival;
        end
    end

endmodule

`default_nettype wire

// ===== design/multi_channel_tick_timer.sv =====
// Top level of the multi-channel tick timer: command control, cell chain, result register.
//
//  channel  | direction | handshake               | fields
//  ---------+-----------+-------------------------+------------------------------------------
//  command  | in        | i_in_valid / o_in_stall | command, timer_slot, initial_count,
//           |           |                         | reload_interval, tick_count
//  event    | out       | o_out_valid/i_out_stall | event_kind, event_slot, last
//
// One command item at a time. A token walks the chain of SLOT_COUNT cells, one cell
// a cycle while the walk is not paused; after the walk a failed create issues a
// failed item, and every command then issues its done item.
// The walk pauses in any cycle where the result register is full and stalled.
// Reset (synchronous, active low) empties the table at once; no clearing pass.
// A new item is taken as soon as the done item sits in the result register.
`default_nettype none

module multi_channel_tick_timer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [1:0]                       i_command,
    input  logic [mctt_pkg::SLOT_W-1:0]      i_timer_slot,
    input  logic [mctt_pkg::COUNT_W-1:0]     i_initial_count,
    input  logic [mctt_pkg::COUNT_W-1:0]     i_reload_interval,
    input  logic [mctt_pkg::TICK_W-1:0]      i_tick_count,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [1:0]                       o_event_kind,
    output logic [mctt_pkg::SLOT_W-1:0]      o_event_slot,
    output logic                             o_last
);
    import mctt_pkg::*;

    t_state            r_state;
    t_state            n_state;
    logic              r_start;
    logic              n_start;
    t_job              r_job;

    logic              r_out_valid;
    logic              n_out_valid;
    t_kind             r_kind;
    t_kind             n_kind;
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] n_slot;
    logic              r_last;
    logic              n_last;

    logic              accept;
    logic              out_free;
    logic              any_fire;
    logic [SLOT_W-1:0] fire_slot;

    t_tok              tok_chain [SLOT_COUNT+1];
    logic              fire      [SLOT_COUNT];

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    // chain and result register move together: the walk stalls with the output
    assign out_free   = !r_out_valid || !i_out_stall;

    assign tok_chain[0] = '{valid: r_start, claimed: 1'b0};

    for (genvar k = 0; k < SLOT_COUNT; k++) begin : g_cell
        mctt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (out_free),
            .i_index (SLOT_W'(k)),
            .i_job   (r_job),
            .i_tok   (tok_chain[k]),
            .o_tok   (tok_chain[k+1]),
            .o_fire  (fire[k])
        );
    end

    // only the cell holding the token can fire, so an OR picks its slot
    always_comb begin
        any_fire  = 1'b0;
        fire_slot = '0;
        for (int k = 0; k < SLOT_COUNT; k++) begin
            any_fire  = any_fire | fire[k];
            fire_slot = fire_slot | (fire[k] ? SLOT_W'(k) : '0);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_start     = r_start;
        n_out_valid = r_out_valid && i_out_stall;
        n_kind      = r_kind;
        n_slot      = r_slot;
        n_last      = r_last;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_RUN;
                    n_start = 1'b1;
                end
            end
            ST_RUN: begin
                if (out_free) begin
                    n_start = 1'b0;
                    if (any_fire) begin
                        n_out_valid = 1'b1;
                        n_kind      = (r_job.cmd == CMD_CREATE) ? KIND_CREATED : KIND_EXPIRED;
                        n_slot      = fire_slot;
                        n_last      = 1'b0;
                    end
                    // token leaving the last cell ends the walk
                    if (tok_chain[SLOT_COUNT].valid) begin
                        if ((r_job.cmd == CMD_CREATE) && !tok_chain[SLOT_COUNT].claimed) begin
                            n_state = ST_FAIL;
                        end else begin
                            n_state = ST_DONE;
                        end
                    end
                end
            end
            ST_FAIL: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_FAILED;
                    n_slot      = '0;
                    n_last      = 1'b0;
                    n_state     = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_DONE;
                    n_slot      = '0;
                    n_last      = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_start     <= n_start;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_slot <= n_slot;
        r_last <= n_last;
        if (accept) begin
            r_job.cmd   <= t_cmd'(i_command);
            r_job.slot  <= i_timer_slot;
            r_job.init  <= i_initial_count;
            r_job.ival  <= i_reload_interval;
            r_job.ticks <= i_tick_count;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_event_kind = r_kind;
    assign o_event_slot = r_slot;
    assign o_last       = r_last;

endmodule

`default_nettype wire
